/* hdl/ccdh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ccdh_pkg: shared types and constants of the charge counter
// Transfer payloads, operation, register and state codes, ring control and divider status.
// ----------------------------------------------------------------------------
package ccdh_pkg;

  localparam int HISTORY_DAYS_DEF = 30;

  localparam int CHARGE_W   = 48;
  localparam int CURRENT_W  = 12;
  localparam int TIME_W     = 32;
  localparam int DAY_W      = 9;
  localparam int INTERVAL_W = 16;
  localparam int THRESH_W   = 32;
  localparam int ACTIVE_W   = 5;
  localparam int PROD_W     = CURRENT_W + TIME_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CHARGE_W-1:0]   CHARGE_MAX       = {CHARGE_W{1'b1}};
  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = INTERVAL_W'(1000);
  localparam logic [THRESH_W-1:0]   THRESHOLD_RST    = THRESH_W'(360000);

  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_CLR_TODAY = 2'd1,
    OP_CLR_HIST  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_INTERVAL = 1'b0,
    REG_THRESHOLD    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_APPLY,
    ST_SWEEP,
    ST_DIV_GO,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [1:0]           operation;
    logic [CURRENT_W-1:0] current_ma;
    logic [TIME_W-1:0]    now_ms;
    logic                 time_valid;
    logic [DAY_W-1:0]     day_of_year;
  } in_item_t;

  typedef struct packed {
    logic [CHARGE_W-1:0] today_total;
    logic [CHARGE_W-1:0] history_total;
    logic [ACTIVE_W-1:0] active_days;
    logic [CHARGE_W-1:0] daily_average;
    logic                rolled_over;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } ring_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

/* hdl/ccdh_ring.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ccdh_ring: daily history store
// Synchronous memory, one write and one registered read port, with a valid
// bit per entry so that reset and a history clear read back as zero.
// ----------------------------------------------------------------------------
module ccdh_ring #(
  parameter int DEPTH = ccdh_pkg::HISTORY_DAYS_DEF,
  parameter int IDX_W = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ccdh_pkg::ring_ctrl_t          ctrl,
  input  wire logic [IDX_W-1:0]              wr_addr,
  input  wire logic [ccdh_pkg::CHARGE_W-1:0] wr_data,
  input  wire logic [IDX_W-1:0]              rd_addr,
  output logic      [ccdh_pkg::CHARGE_W-1:0] rd_data
);
  import ccdh_pkg::*;

  logic [CHARGE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    vld;
  logic [CHARGE_W-1:0] rd_q;
  logic                rd_vld_q;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        vld <= '0;
      end else if (ctrl.wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

/* hdl/ccdh_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ccdh_div: bit-serial restoring divider
// One quotient bit per cycle; done pulses for a single cycle, in the cycle after the last step.
// ----------------------------------------------------------------------------
module ccdh_div #(
  parameter int DVD_W = 53,
  parameter int DVS_W = 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [DVD_W-1:0]        dividend,
  input  wire logic [DVS_W-1:0]        divisor,
  output logic      [DVD_W-1:0]        quotient,
  output ccdh_pkg::div_status_t        status
);
  import ccdh_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  work;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs_q;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  always_comb begin
    trial = {rem, work[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && !start && (steps == STEP_W'(1));
      if (start) begin
        work  <= dividend;
        rem   <= '0;
        dvs_q <= divisor;
        steps <= STEP_W'(DVD_W);
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        work  <= {work[DVD_W-2:0], ge};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient    = work;
  assign status.busy = busy;
  assign status.done = done;

endmodule
`default_nettype wire

/* hdl/charge_counter_daily_history.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// charge_counter_daily_history: coulomb counter with a daily history ring
// Integrates current over time into today's charge and keeps a ring of past
// days with total, active count and active mean.
// ----------------------------------------------------------------------------
// Each input transfer yields one result after these steps in order: the 12 x 32
// bit multiply, the update of today's charge and the ring write, a sweep of the
// ring memory through its single read port for the sums, and the serial divider
// for the mean. Inputs are taken one at a time; the next input is accepted while
// a result still waits in the output register. The history reads as zero
// straight after reset.
module charge_counter_daily_history #(
  parameter int HISTORY_DAYS = ccdh_pkg::HISTORY_DAYS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ccdh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ccdh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire ccdh_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output ccdh_pkg::out_item_t                  out_data
);
  import ccdh_pkg::*;

  localparam int IDX_W = (HISTORY_DAYS > 1) ? $clog2(HISTORY_DAYS) : 1;
  localparam int CNT_W = $clog2(HISTORY_DAYS + 1);
  localparam int SUM_W = CHARGE_W + CNT_W;

  state_t state, state_next;

  logic [INTERVAL_W-1:0] min_interval;
  logic [THRESH_W-1:0]   threshold;

  in_item_t            item_q;
  logic [CHARGE_W-1:0] today;
  logic [TIME_W-1:0]   last_ms;
  logic [DAY_W-1:0]    last_day;
  logic                seen;
  logic [IDX_W-1:0]    head;
  logic [PROD_W-1:0]   prod;
  logic                back;
  logic                dt_ok;
  logic                rolled;
  logic [SUM_W-1:0]    acc_total;
  logic [SUM_W-1:0]    acc_act;
  logic [CNT_W-1:0]    acc_cnt;
  logic [CNT_W-1:0]    sweep_cnt;
  logic [CHARGE_W-1:0] avg;

  logic [TIME_W-1:0]   dt;
  logic [CHARGE_W:0]   sum_wide;
  logic [CHARGE_W-1:0] today_int;
  logic                is_sample;
  logic                do_roll;
  logic                sweep_last;
  logic                accept;
  logic                out_load;
  logic                div_start;
  ring_ctrl_t          ring_ctrl;
  logic [CHARGE_W-1:0] rd_data;
  logic [SUM_W-1:0]    quotient;
  div_status_t         div_st;
  logic [CHARGE_W-1:0] hist_sat;

  assign accept     = in_valid && !in_stall;
  assign sweep_last = sweep_cnt == CNT_W'(HISTORY_DAYS);

  always_comb begin
    dt        = item_q.now_ms - last_ms;
    sum_wide  = {1'b0, today} + (CHARGE_W + 1)'(prod);
    today_int = !dt_ok ? today : (sum_wide[CHARGE_W] ? CHARGE_MAX : sum_wide[CHARGE_W-1:0]);
    is_sample = item_q.operation == OP_SAMPLE;
    do_roll   = is_sample && !back && item_q.time_valid && seen
                && (item_q.day_of_year != last_day);
    hist_sat  = (acc_total > SUM_W'(CHARGE_MAX)) ? CHARGE_MAX : acc_total[CHARGE_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_MUL;
      ST_MUL:    state_next = ST_APPLY;
      ST_APPLY:  state_next = ST_SWEEP;
      ST_SWEEP:  if (sweep_last) state_next = ST_DIV_GO;
      ST_DIV_GO: state_next = ST_DIV;
      ST_DIV:    if (div_st.done) state_next = ST_HOLD;
      ST_HOLD:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = state != ST_IDLE;
    ring_ctrl.wr_en = (state == ST_APPLY) && do_roll;
    ring_ctrl.clear = (state == ST_APPLY) && (item_q.operation == OP_CLR_HIST);
    ring_ctrl.rd_en = (state == ST_SWEEP) && !sweep_last;
    div_start       = state == ST_DIV_GO;
    out_load        = (state == ST_HOLD) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= MIN_INTERVAL_RST;
      threshold    <= THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MIN_INTERVAL: min_interval <= cfg_data[INTERVAL_W-1:0];
        REG_THRESHOLD:    threshold    <= cfg_data[THRESH_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      today    <= '0;
      last_ms  <= '0;
      last_day <= '0;
      seen     <= 1'b0;
      head     <= '0;
    end else if (state == ST_APPLY) begin
      unique case (op_t'(item_q.operation))
        OP_SAMPLE: begin
          if (back) begin
            last_ms <= item_q.now_ms;
          end else begin
            today <= do_roll ? '0 : today_int;
            if (dt_ok) begin
              last_ms <= item_q.now_ms;
            end
            if (item_q.time_valid && !seen) begin
              seen     <= 1'b1;
              last_day <= item_q.day_of_year;
            end else if (do_roll) begin
              last_day <= item_q.day_of_year;
              head     <= (head == IDX_W'(HISTORY_DAYS - 1)) ? '0 : head + IDX_W'(1);
            end
          end
        end
        OP_CLR_TODAY: today <= '0;
        OP_CLR_HIST:  ;
        default:      ;
      endcase
    end
  end

  // input capture, multiply, sweep and mean capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= in_data;
    end
    if (state == ST_MUL) begin
      back  <= item_q.now_ms < last_ms;
      dt_ok <= dt >= TIME_W'(min_interval);
      prod  <= PROD_W'(item_q.current_ma) * PROD_W'(dt);
    end
    if (state == ST_APPLY) begin
      rolled    <= do_roll;
      acc_total <= '0;
      acc_act   <= '0;
      acc_cnt   <= '0;
      sweep_cnt <= '0;
    end
    if (state == ST_SWEEP) begin
      sweep_cnt <= sweep_cnt + CNT_W'(1);
      if (sweep_cnt != '0) begin
        acc_total <= acc_total + SUM_W'(rd_data);
        if (rd_data > CHARGE_W'(threshold)) begin
          acc_act <= acc_act + SUM_W'(rd_data);
          acc_cnt <= acc_cnt + CNT_W'(1);
        end
      end
    end
    if ((state == ST_DIV) && div_st.done) begin
      avg <= (acc_cnt == '0) ? '0 : quotient[CHARGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.today_total   <= today;
      out_data.history_total <= hist_sat;
      out_data.active_days   <= ACTIVE_W'(acc_cnt);
      out_data.daily_average <= avg;
      out_data.rolled_over   <= rolled;
    end
  end

  ccdh_ring #(
    .DEPTH (HISTORY_DAYS),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ring_ctrl),
    .wr_addr (head),
    .wr_data (today_int),
    .rd_addr (sweep_cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  ccdh_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_act),
    .divisor  (acc_cnt),
    .quotient (quotient),
    .status   (div_st)
  );

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_MUL)
    else $error("accepted transfer did not start processing");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending transfer");

  a_div_window: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head < IDX_W'(HISTORY_DAYS))
    else $error("history head out of range");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    ring_ctrl.wr_en |-> !ring_ctrl.rd_en && !ring_ctrl.clear)
    else $error("ring write overlaps a read or clear");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the charge counter with daily history
// Drives sample and manual transfers with random gaps and output stalls,
// predicts every report from a cycle-free model of the charge ledger, and
// compares each report field by field in arrival order. Runs several register
// settings, including the extremes, and forces the block to back up.
// ----------------------------------------------------------------------------
module tb_top;
  import ccdh_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int          SETTLE_CYCLES = 100;
  localparam int          PHASE_ITEMS   = 290;
  localparam int          N_PHASES      = 6;
  localparam int          HOLD_CYCLES   = 600;
  localparam logic [1:0]  OP_SPARE      = 2'd3;

  class charge_ledger;
    bit [INTERVAL_W-1:0] min_interval;
    bit [THRESH_W-1:0]   threshold;
    bit [CHARGE_W-1:0]   today;
    bit [CHARGE_W-1:0]   ring [HISTORY_DAYS_DEF];
    int unsigned         head;
    bit [TIME_W-1:0]     last_ms;
    bit [DAY_W-1:0]      last_day;
    bit                  day_seen;
    out_item_t           pending_reports [$];
    int unsigned         items_taken, reports_checked, mismatches, rollovers, full_days;

    function new();
      min_interval = MIN_INTERVAL_RST;
      threshold    = THRESHOLD_RST;
    endfunction

    function void set_config(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_MIN_INTERVAL: min_interval = value[INTERVAL_W-1:0];
        REG_THRESHOLD:    threshold    = value[THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_item(in_item_t it);
      bit [63:0]       add, sum, tot, act;
      bit [TIME_W-1:0] dt;
      int unsigned     cnt;
      out_item_t       r;
      r   = '0;
      tot = '0;
      act = '0;
      cnt = 0;
      case (it.operation)
        OP_SAMPLE: begin
          if (it.now_ms < last_ms) begin
            last_ms = it.now_ms;
          end else begin
            dt = it.now_ms - last_ms;
            if (dt >= TIME_W'(min_interval)) begin
              add     = 64'(it.current_ma) * 64'(dt);
              sum     = 64'(today) + add;
              today   = (sum > 64'(CHARGE_MAX)) ? CHARGE_MAX : sum[CHARGE_W-1:0];
              last_ms = it.now_ms;
            end
            if (it.time_valid) begin
              if (!day_seen) begin
                day_seen = 1'b1;
                last_day = it.day_of_year;
              end else if (it.day_of_year != last_day) begin
                last_day   = it.day_of_year;
                ring[head] = today;
                if (today == CHARGE_MAX) full_days++;
                head          = (head + 1) % HISTORY_DAYS_DEF;
                today         = '0;
                r.rolled_over = 1'b1;
                rollovers++;
              end
            end
          end
        end
        OP_CLR_TODAY: today = '0;
        OP_CLR_HIST: begin
          foreach (ring[i]) ring[i] = '0;
        end
        default: ;
      endcase
      foreach (ring[i]) begin
        tot += 64'(ring[i]);
        if (ring[i] > CHARGE_W'(threshold)) begin
          act += 64'(ring[i]);
          cnt++;
        end
      end
      r.today_total   = today;
      r.history_total = (tot > 64'(CHARGE_MAX)) ? CHARGE_MAX : tot[CHARGE_W-1:0];
      r.active_days   = ACTIVE_W'(cnt);
      r.daily_average = (cnt == 0) ? '0 : CHARGE_W'(act / 64'(cnt));
      pending_reports.push_back(r);
      items_taken++;
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: today %0d history %0d active %0d average %0d rolled %0b",
                   got.today_total, got.history_total, got.active_days,
                   got.daily_average, got.rolled_over);
        return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      if (got.today_total !== want.today_total || got.history_total !== want.history_total ||
          got.active_days !== want.active_days || got.daily_average !== want.daily_average ||
          got.rolled_over !== want.rolled_over) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report %0d (expected/actual): today %0d/%0d history %0d/%0d",
                   reports_checked, want.today_total, got.today_total,
                   want.history_total, got.history_total,
                   "  active %0d/%0d average %0d/%0d rolled %0b/%0b",
                   want.active_days, got.active_days, want.daily_average,
                   got.daily_average, want.rolled_over, got.rolled_over);
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  charge_ledger          ledger    = new();
  int unsigned           cycle_count = 0;
  int unsigned           hold_asks   = 0;
  bit [TIME_W-1:0]       t_now       = '0;
  bit [DAY_W-1:0]        t_day       = '0;

  charge_counter_daily_history dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t mk_item(logic [1:0] op, logic [CURRENT_W-1:0] cur,
                                       logic [TIME_W-1:0] now, logic tv,
                                       logic [DAY_W-1:0] day);
    in_item_t it;
    it.operation   = op;
    it.current_ma  = cur;
    it.now_ms      = now;
    it.time_valid  = tv;
    it.day_of_year = day;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    return mk_item(2'($urandom_range(0, 3)), CURRENT_W'($urandom), $urandom,
                   1'($urandom), DAY_W'($urandom_range(0, 511)));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic void step_clock(logic [INTERVAL_W-1:0] interval);
    bit [TIME_W:0] nxt;
    int unsigned   q;
    q = $urandom_range(0, 99);
    if (q < 65)
      nxt = (TIME_W+1)'(t_now) + (TIME_W+1)'(interval) + (TIME_W+1)'($urandom_range(0, 2000));
    else if (q < 80 && interval != 0)
      nxt = (TIME_W+1)'(t_now) + (TIME_W+1)'($urandom_range(0, interval - 1));
    else if (q < 93)
      nxt = (TIME_W+1)'(t_now) + (TIME_W+1)'($urandom_range(0, 1 << 22));
    else
      nxt = (TIME_W+1)'($urandom_range(0, t_now));
    t_now = nxt[TIME_W] ? TIME_W'($urandom_range(0, 1000)) : nxt[TIME_W-1:0];
  endfunction

  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.take_item(it);
  endtask

  task automatic push(in_item_t it, bit calm);
    int unsigned gap;
    send_item(it);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic [INTERVAL_W-1:0] interval, logic [THRESH_W-1:0] thresh);
    logic [CFG_DATA_W-1:0] word;
    word      = {16'($urandom), interval};
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MIN_INTERVAL;
    cfg_data  <= word;
    @(posedge clk);
    ledger.set_config(REG_MIN_INTERVAL, word);
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= thresh;
    @(posedge clk);
    ledger.set_config(REG_THRESHOLD, thresh);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(int phase_no, logic [INTERVAL_W-1:0] interval);
    int unsigned sent, r, n, k;
    bit          calm, held, paused;
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (sent < PHASE_ITEMS) begin
      if (phase_no == 1 && !held && sent >= 100) begin
        hold_asks++;
        held = 1'b1;
      end
      if (phase_no == 3 && !paused && sent >= 150) begin
        drain();
        paused = 1'b1;
      end
      calm = ($urandom_range(0, 5) == 0);
      r    = $urandom_range(0, 99);
      if (r < 62) begin
        n = $urandom_range(3, 15);
        for (k = 0; k < n; k++) begin
          step_clock(interval);
          push(mk_item(OP_SAMPLE, CURRENT_W'($urandom_range(0, 4095)), t_now,
                       $urandom_range(0, 11) != 0,
                       ($urandom_range(0, 15) == 0) ? DAY_W'($urandom_range(0, 511)) : t_day),
               calm);
        end
        t_day = ($urandom_range(0, 9) == 0) ? DAY_W'($urandom_range(0, 511))
                                            : DAY_W'((t_day + 1) % 366);
        sent += n;
      end else if (r < 70) begin
        // drive today's charge towards saturation
        n = $urandom_range(10, 20);
        for (k = 0; k < n; k++) begin
          push(mk_item(OP_SAMPLE, CURRENT_W'($urandom_range(4000, 4095)), '0, 1'b1, t_day),
               calm);
          push(mk_item(OP_SAMPLE, CURRENT_W'($urandom_range(4000, 4095)), '1, 1'b1, t_day),
               calm);
        end
        t_now = '1;
        sent += 2 * n;
      end else if (r < 82) begin
        push(mk_item(($urandom_range(0, 3) == 0) ? OP_CLR_HIST : OP_CLR_TODAY,
                     CURRENT_W'($urandom), $urandom, 1'($urandom), DAY_W'($urandom)), calm);
        sent++;
      end else if (r < 92) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) push(noise_item(), calm);
        sent += n;
      end else begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) begin
          step_clock(interval);
          push(mk_item(OP_SAMPLE, CURRENT_W'($urandom), t_now, 1'b0,
                       DAY_W'($urandom_range(0, 511))), calm);
        end
        sent += n;
      end
    end
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : receiver
    int unsigned hold_done, hold_left, calm_left, stall_left, r;
    logic        stall_next;
    hold_done  = 0;
    hold_left  = 0;
    calm_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) ledger.check_report(out_data);
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        stall_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else begin
        r          = $urandom_range(0, 99);
        stall_next = 1'b0;
        if (r < 8) begin
          calm_left = $urandom_range(50, 300);
        end else if (r >= 55) begin
          stall_next = 1'b1;
          if (r < 90) stall_left = $urandom_range(0, 2);
          else if (r < 97) stall_left = $urandom_range(3, 14);
          else stall_left = $urandom_range(30, 80);
        end
      end
      out_stall <= stall_next;
    end
  end

  initial begin : stimulus
    logic [INTERVAL_W-1:0] intervals [N_PHASES];
    logic [THRESH_W-1:0]   thresholds [N_PHASES];
    intervals  = '{16'd1, 16'hFFFF, 16'd0, INTERVAL_W'($urandom), 16'd1000,
                   INTERVAL_W'($urandom_range(1, 5000))};
    thresholds = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd360000,
                   32'($urandom_range(0, 1000000)), $urandom};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push(mk_item(OP_SAMPLE,    12'h000, 32'd0,         1'b0, 9'd0),   1'b0);
    push(mk_item(OP_SAMPLE,    12'hFFF, 32'd1000,      1'b1, 9'd5),   1'b0);
    push(mk_item(OP_SAMPLE,    12'd100, 32'd1500,      1'b1, 9'd5),   1'b0);
    push(mk_item(OP_SAMPLE,    12'd100, 32'd2000,      1'b1, 9'd6),   1'b0);
    push(mk_item(OP_SAMPLE,    12'd50,  32'd1000,      1'b1, 9'd7),   1'b0);
    push(mk_item(OP_SAMPLE,    12'hFFF, 32'hFFFF_FFFF, 1'b1, 9'd7),   1'b0);
    push(mk_item(OP_SAMPLE,    12'hFFF, 32'hFFFF_FFFF, 1'b0, 9'd365), 1'b0);
    push(mk_item(OP_CLR_TODAY, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 9'h1FF), 1'b0);
    push(mk_item(OP_SAMPLE,    12'hABC, 32'd0,         1'b1, 9'h1FF), 1'b0);
    push(mk_item(OP_SAMPLE,    12'hFFF, 32'hFFFF_FFFF, 1'b1, 9'h1FF), 1'b0);
    push(mk_item(OP_SAMPLE,    12'h000, 32'hFFFF_FFFF, 1'b1, 9'd400), 1'b0);
    push(mk_item(OP_CLR_HIST,  12'h000, 32'd0,         1'b0, 9'd0),   1'b0);
    push(mk_item(OP_SPARE,     12'h555, 32'hAAAA_AAAA, 1'b1, 9'h0AA), 1'b0);
    push(mk_item(OP_SAMPLE,    12'h2AA, 32'h5555_5555, 1'b1, 9'h155), 1'b0);
    push(mk_item(OP_CLR_TODAY, 12'h000, 32'd0,         1'b0, 9'd0),   1'b0);
    push(mk_item(OP_SAMPLE,    12'h555, 32'h5555_9999, 1'b1, 9'h0AA), 1'b0);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_config(intervals[p], thresholds[p]);
      run_phase(p, intervals[p]);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d transfers over %0d register settings; %0d reports checked.",
             ledger.items_taken, N_PHASES + 1, ledger.reports_checked);
    $display("Day rollovers: %0d, saturated days stored: %0d, mismatches: %0d, owed: %0d.",
             ledger.rollovers, ledger.full_days, ledger.mismatches,
             ledger.pending_reports.size());
    if (ledger.mismatches == 0 && ledger.pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
